/* src/spft_pkg.sv */
// Shared types and constants for the sorted PCI function table.
package spft_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int LOC_W = 40;
    localparam int IDN_W = 56;
    localparam int KEY_W = LOC_W + IDN_W;
    localparam logic [7:0] DEVICE_MAX = 8'd31;
    localparam logic [7:0] FUNCTION_MAX = 8'd7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FORMAT = 2'd1,
        ST_FULL   = 2'd2,
        ST_INDEX  = 2'd3
    } status_t;

    // RAM read address source
    typedef enum logic [1:0] {
        RD_IDX      = 2'd0,
        RD_COUNT_M1 = 2'd1,
        RD_POS_M2   = 2'd2
    } rd_src_t;

    typedef struct packed {
        logic    capture;
        logic    init_pos;
        logic    shift;
        logic    place;
        logic    clear;
        logic    rd_en;
        rd_src_t rd_src;
        logic    load_data;
        logic    set_status;
        status_t status_code;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic fmt_err;
        logic full;
        logic count_zero;
        logic idx_ok;
        logic key_less;
        logic pos_is_one;
    } dp_stat_t;

endpackage

/* src/spft_ram.sv */
// Generic simple dual-port RAM with registered read.
module spft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/spft_datapath.sv */
// Datapath: item capture, table RAM, insertion pointer, entry count, result registers.
module spft_datapath #(
    parameter int TABLE_DEPTH = spft_pkg::DEFAULT_TABLE_DEPTH,
    parameter int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  spft_pkg::dp_cmd_t   cmd,
    output spft_pkg::dp_stat_t  stat,
    input  logic [1:0]          op,
    input  logic [15:0]         segment,
    input  logic [7:0]          bus,
    input  logic [7:0]          device_number,
    input  logic [7:0]          function_number,
    input  logic [15:0]         vendor,
    input  logic [15:0]         product,
    input  logic [7:0]          class_byte,
    input  logic [7:0]          subclass_byte,
    input  logic [7:0]          interface_byte,
    input  logic [AW-1:0]       read_index,
    output logic [1:0]          status,
    output logic [CW-1:0]       entry_count,
    output logic [spft_pkg::LOC_W-1:0] entry_location,
    output logic [spft_pkg::IDN_W-1:0] entry_identity
);
    import spft_pkg::*;

    op_t              op_reg;
    logic             fmt_reg;
    logic [KEY_W-1:0] key_reg;
    logic [AW-1:0]    idx_reg;
    logic [AW-1:0]    pos_reg;
    logic [CW-1:0]    count_reg;
    status_t          res_status_reg;
    logic [KEY_W-1:0] res_data_reg;
    status_t          out_status_reg;
    logic [CW-1:0]    out_count_reg;
    logic [KEY_W-1:0] out_data_reg;

    logic             wr_en;
    logic [AW-1:0]    rd_addr;
    logic [KEY_W-1:0] wr_data;
    logic [KEY_W-1:0] rd_data;

    always_comb
    begin
        unique case (cmd.rd_src)
            RD_IDX:      rd_addr = idx_reg;
            RD_COUNT_M1: rd_addr = count_reg[AW-1:0] - AW'(1);
            RD_POS_M2:   rd_addr = pos_reg - AW'(2);
            default:     rd_addr = idx_reg;
        endcase
    end

    // shifting moves the entry just read up by one; placing writes the new key
    assign wr_en   = cmd.shift | cmd.place;
    assign wr_data = cmd.shift ? rd_data : key_reg;

    spft_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (pos_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.clear)
        begin
            count_reg <= '0;
        end
        else if (cmd.place)
        begin
            count_reg <= count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op_t'(op);
            fmt_reg <= (device_number > DEVICE_MAX) || (function_number > FUNCTION_MAX);
            key_reg <= {segment, bus, device_number, function_number,
                        vendor, product, class_byte, subclass_byte, interface_byte};
            idx_reg <= read_index;
        end

        if (cmd.init_pos)
        begin
            pos_reg <= count_reg[AW-1:0];
        end
        else if (cmd.shift)
        begin
            pos_reg <= pos_reg - AW'(1);
        end

        if (cmd.capture)
        begin
            res_status_reg <= ST_OK;
            res_data_reg   <= '0;
        end
        else
        begin
            if (cmd.set_status)
            begin
                res_status_reg <= cmd.status_code;
            end
            if (cmd.load_data)
            begin
                res_data_reg <= rd_data;
            end
        end

        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_count_reg  <= count_reg;
            out_data_reg   <= res_data_reg;
        end
    end

    assign stat.op         = op_reg;
    assign stat.fmt_err    = fmt_reg;
    assign stat.full       = (count_reg == CW'(TABLE_DEPTH));
    assign stat.count_zero = (count_reg == '0);
    assign stat.idx_ok     = (CW'(idx_reg) < count_reg);
    assign stat.key_less   = (key_reg < rd_data);
    assign stat.pos_is_one = (pos_reg == AW'(1));

    assign status         = out_status_reg;
    assign entry_count    = out_count_reg;
    assign entry_location = out_data_reg[KEY_W-1:IDN_W];
    assign entry_identity = out_data_reg[IDN_W-1:0];

endmodule

/* src/spft_ctrl.sv */
// Controller: sequences decode, insertion shifting, reads and result delivery.
module spft_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  spft_pkg::dp_stat_t  stat,
    output spft_pkg::dp_cmd_t   cmd
);
    import spft_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT,
        S_PLACE,
        S_RDWAIT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd            = '0;
        cmd.rd_src     = RD_IDX;
        cmd.status_code = ST_OK;
        state_next     = state_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                unique case (stat.op)
                    OP_INSERT:
                    begin
                        if (stat.fmt_err)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_FORMAT;
                            state_next      = S_FINISH;
                        end
                        else if (stat.full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_FULL;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            cmd.init_pos = 1'b1;
                            cmd.rd_en    = 1'b1;
                            cmd.rd_src   = RD_COUNT_M1;
                            state_next   = stat.count_zero ? S_PLACE : S_SHIFT;
                        end
                    end
                    OP_READ:
                    begin
                        if (stat.idx_ok)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_src = RD_IDX;
                            state_next = S_RDWAIT;
                        end
                        else
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_INDEX;
                            state_next      = S_FINISH;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_FINISH;
                    end
                    OP_NONE:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SHIFT:
            begin
                // entry below the insertion point is on the read port
                if (stat.key_less)
                begin
                    cmd.shift  = 1'b1;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = RD_POS_M2;
                    state_next = stat.pos_is_one ? S_PLACE : S_SHIFT;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_FINISH;
            end
            S_RDWAIT:
            begin
                cmd.load_data = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* src/sorted_pci_function_table_unit.sv */
// Top level of the sorted PCI function table: controller, datapath and checks.
// Keeps up to TABLE_DEPTH PCI function records in ascending order of the 96-bit key
// {segment, bus, device, function, vendor, product, class, subclass, interface}; equal
// keys stay in arrival order. One item is in work at a time and every item gives
// exactly one result. In an accepted insert, every held entry greater than the new
// record is moved up one slot per cycle through the single table RAM (one read and
// one write port, registered read). A waiting result is held in an output register,
// so the next item can be taken before it is transferred.
module sorted_pci_function_table_unit #(
    parameter int TABLE_DEPTH = spft_pkg::DEFAULT_TABLE_DEPTH,
    parameter int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          op,
    input  logic [15:0]         segment,
    input  logic [7:0]          bus,
    input  logic [7:0]          device_number,
    input  logic [7:0]          function_number,
    input  logic [15:0]         vendor,
    input  logic [15:0]         product,
    input  logic [7:0]          class_byte,
    input  logic [7:0]          subclass_byte,
    input  logic [7:0]          interface_byte,
    input  logic [AW-1:0]       read_index,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [CW-1:0]       entry_count,
    output logic [spft_pkg::LOC_W-1:0] entry_location,
    output logic [spft_pkg::IDN_W-1:0] entry_identity
);
    import spft_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    spft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    spft_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .op              (op),
        .segment         (segment),
        .bus             (bus),
        .device_number   (device_number),
        .function_number (function_number),
        .vendor          (vendor),
        .product         (product),
        .class_byte      (class_byte),
        .subclass_byte   (subclass_byte),
        .interface_byte  (interface_byte),
        .read_index      (read_index),
        .status          (status),
        .entry_count     (entry_count),
        .entry_location  (entry_location),
        .entry_identity  (entry_identity)
    );

    // one item in work at a time
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after a transfer");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= TABLE_DEPTH)
        else $error("entry count beyond table depth");

    a_error_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> entry_location == '0 && entry_identity == '0)
        else $error("error result carries entry data");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> entry_count == TABLE_DEPTH)
        else $error("table-full result with table not full");

endmodule

/* bench/spft_checker.sv */
// Checker for the sorted PCI function table: tracks the expected table and compares results.
module spft_checker #(
    parameter int DEPTH = spft_pkg::DEFAULT_TABLE_DEPTH,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW = $clog2(DEPTH + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [1:0]                 op,
    input  logic [15:0]                segment,
    input  logic [7:0]                 bus,
    input  logic [7:0]                 device_number,
    input  logic [7:0]                 function_number,
    input  logic [15:0]                vendor,
    input  logic [15:0]                product,
    input  logic [7:0]                 class_byte,
    input  logic [7:0]                 subclass_byte,
    input  logic [7:0]                 interface_byte,
    input  logic [AW-1:0]              read_index,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [1:0]                 status,
    input  logic [CW-1:0]              entry_count,
    input  logic [spft_pkg::LOC_W-1:0] entry_location,
    input  logic [spft_pkg::IDN_W-1:0] entry_identity,
    output int                         fail_count,
    output int                         pending,
    output int                         placed_count,
    output int                         full_count,
    output int                         format_count,
    output int                         hit_count,
    output int                         miss_count,
    output int                         clear_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import spft_pkg::*;

    typedef struct packed {
        status_t          status;
        logic [CW-1:0]    count;
        logic [LOC_W-1:0] loc;
        logic [IDN_W-1:0] idn;
    } table_answer_t;

    logic [LOC_W-1:0] loc_tab [DEPTH];
    logic [IDN_W-1:0] idn_tab [DEPTH];
    int               held;
    table_answer_t    awaited_answers [$];

    // Updates the expected table for one command and returns the answer it should give.
    function automatic table_answer_t apply_command(
        input logic [1:0]       cmd,
        input logic [LOC_W-1:0] loc,
        input logic [IDN_W-1:0] idn,
        input logic [AW-1:0]    idx
    );
        table_answer_t a;
        int pos;
        a = '0;
        a.status = ST_OK;
        case (op_t'(cmd))
            OP_INSERT:
            begin
                // bad device/function wins over a full table
                if (loc[15:8] > DEVICE_MAX || loc[7:0] > FUNCTION_MAX)
                begin
                    a.status = ST_FORMAT;
                    format_count++;
                end
                else if (held >= DEPTH)
                begin
                    a.status = ST_FULL;
                    full_count++;
                end
                else
                begin
                    pos = held;
                    // strictly greater entries move up, equal ones stay ahead
                    while (pos != 0 && {loc, idn} < {loc_tab[pos-1], idn_tab[pos-1]})
                    begin
                        loc_tab[pos] = loc_tab[pos-1];
                        idn_tab[pos] = idn_tab[pos-1];
                        pos--;
                    end
                    loc_tab[pos] = loc;
                    idn_tab[pos] = idn;
                    held++;
                    placed_count++;
                end
            end
            OP_READ:
            begin
                if (idx < held)
                begin
                    a.loc = loc_tab[idx];
                    a.idn = idn_tab[idx];
                    hit_count++;
                end
                else
                begin
                    a.status = ST_INDEX;
                    miss_count++;
                end
            end
            OP_CLEAR:
            begin
                held = 0;
                clear_count++;
            end
            default: ;
        endcase
        a.count = CW'(held);
        return a;
    endfunction

    task automatic note_mismatch(input string what, input logic [IDN_W-1:0] want,
                                 input logic [IDN_W-1:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        table_answer_t want;
        if (!rst_n)
        begin
            held = 0;
            awaited_answers.delete();
            fail_count = 0;
            placed_count = 0;
            full_count = 0;
            format_count = 0;
            hit_count = 0;
            miss_count = 0;
            clear_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_answers.size() == 0)
                begin
                    $display("%0t: result transfer with none expected, status %0d count %0d",
                             $time, status, entry_count);
                    fail_count++;
                end
                else
                begin
                    want = awaited_answers.pop_front();
                    if (status !== want.status)
                        note_mismatch("status", IDN_W'(want.status), IDN_W'(status));
                    if (entry_count !== want.count)
                        note_mismatch("entry_count", IDN_W'(want.count), IDN_W'(entry_count));
                    if (entry_location !== want.loc)
                        note_mismatch("entry_location", IDN_W'(want.loc),
                                      IDN_W'(entry_location));
                    if (entry_identity !== want.idn)
                        note_mismatch("entry_identity", want.idn, entry_identity);
                end
            end
            if (in_valid && in_ready)
                awaited_answers.push_back(apply_command(
                    op,
                    {segment, bus, device_number, function_number},
                    {vendor, product, class_byte, subclass_byte, interface_byte},
                    read_index));
        end
        pending <= awaited_answers.size();
    end

endmodule

/* bench/tb_top.sv */
// Testbench top for the sorted PCI function table: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import spft_pkg::*;

    localparam int DEPTH = DEFAULT_TABLE_DEPTH;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MIXED_ITEMS = 850;

    typedef struct packed {
        op_t           op;
        logic [15:0]   segment;
        logic [7:0]    bus;
        logic [7:0]    dev;
        logic [7:0]    fn;
        logic [15:0]   vendor;
        logic [15:0]   product;
        logic [7:0]    cls;
        logic [7:0]    sub;
        logic [7:0]    ifc;
        logic [AW-1:0] idx;
    } table_cmd_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [1:0]       op;
    logic [15:0]      segment;
    logic [7:0]       bus;
    logic [7:0]       device_number;
    logic [7:0]       function_number;
    logic [15:0]      vendor;
    logic [15:0]      product;
    logic [7:0]       class_byte;
    logic [7:0]       subclass_byte;
    logic [7:0]       interface_byte;
    logic [AW-1:0]    read_index;
    logic             out_valid;
    logic             out_ready;
    logic [1:0]       status;
    logic [CW-1:0]    entry_count;
    logic [LOC_W-1:0] entry_location;
    logic [IDN_W-1:0] entry_identity;

    int fail_count;
    int pending;
    int placed_count;
    int full_count;
    int format_count;
    int hit_count;
    int miss_count;
    int clear_count;

    bit idling = 1'b1;
    int sent = 0;

    sorted_pci_function_table_unit #(.TABLE_DEPTH(DEPTH)) i_dut (.*);

    spft_checker #(.DEPTH(DEPTH)) i_checker (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Field values biased toward the extremes and tiny values so keys often tie deep.
    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 2));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick8();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'($urandom_range(0, 2));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic table_cmd_t bare(input op_t code);
        table_cmd_t c;
        c = table_cmd_t'({$urandom, $urandom, $urandom, $urandom});
        c.op = code;
        return c;
    endfunction

    function automatic table_cmd_t read_at(input int unsigned idx);
        table_cmd_t c;
        c = bare(OP_READ);
        c.idx = AW'(idx);
        return c;
    endfunction

    function automatic table_cmd_t insert_of(
        input logic [15:0] seg, input logic [7:0] b, input logic [7:0] dev,
        input logic [7:0] fn, input logic [15:0] ven, input logic [15:0] prod,
        input logic [7:0] cls, input logic [7:0] sub, input logic [7:0] ifc
    );
        table_cmd_t c;
        c = bare(OP_INSERT);
        c.segment = seg;
        c.bus = b;
        c.dev = dev;
        c.fn = fn;
        c.vendor = ven;
        c.product = prod;
        c.cls = cls;
        c.sub = sub;
        c.ifc = ifc;
        return c;
    endfunction

    function automatic table_cmd_t rand_record(input int bad_pct);
        table_cmd_t c;
        c = insert_of(pick16(), pick8(), 8'd0, 8'd0, pick16(), pick16(),
                      pick8(), pick8(), pick8());
        c.dev = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 1))
                                            : 8'($urandom_range(0, 31));
        c.fn = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 1))
                                           : 8'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < bad_pct)
        begin
            case ($urandom_range(0, 2))
                0: c.dev = 8'($urandom_range(32, 255));
                1: c.fn = 8'($urandom_range(8, 255));
                default:
                begin
                    c.dev = 8'($urandom_range(32, 255));
                    c.fn = 8'($urandom_range(8, 255));
                end
            endcase
        end
        return c;
    endfunction

    task automatic send_cmd(input table_cmd_t c);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= c.op;
        segment <= c.segment;
        bus <= c.bus;
        device_number <= c.dev;
        function_number <= c.fn;
        vendor <= c.vendor;
        product <= c.product;
        class_byte <= c.cls;
        subclass_byte <= c.sub;
        interface_byte <= c.ifc;
        read_index <= c.idx;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    // Hold the sender until every outstanding result has been transferred.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Fill to capacity, hit the full and format-first cases, then read every slot back.
    task automatic fill_table();
        send_cmd(bare(OP_CLEAR));
        repeat (DEPTH) send_cmd(rand_record(0));
        send_cmd(rand_record(0));
        send_cmd(rand_record(100));
        drain();
        for (int i = 0; i < DEPTH; i++) send_cmd(read_at(i));
        send_cmd(bare(OP_NONE));
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idling && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int r;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        out_ready <= 1'b0;
        op <= OP_NONE;
        segment <= '0;
        bus <= '0;
        device_number <= '0;
        function_number <= '0;
        vendor <= '0;
        product <= '0;
        class_byte <= '0;
        subclass_byte <= '0;
        interface_byte <= '0;
        read_index <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        send_cmd(read_at(0));
        send_cmd(insert_of(16'h0000, 8'h00, 8'd0, 8'd0, 16'h0000, 16'h0000,
                           8'h00, 8'h00, 8'h00));
        send_cmd(insert_of(16'hFFFF, 8'hFF, DEVICE_MAX, FUNCTION_MAX, 16'hFFFF, 16'hFFFF,
                           8'hFF, 8'hFF, 8'hFF));
        send_cmd(insert_of(16'h1234, 8'h10, 8'd32, 8'd0, 16'h1111, 16'h2222,
                           8'h01, 8'h02, 8'h03));
        send_cmd(insert_of(16'h1234, 8'h10, 8'd3, 8'd8, 16'h1111, 16'h2222,
                           8'h01, 8'h02, 8'h03));
        send_cmd(insert_of(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                           8'hFF, 8'hFF, 8'hFF));
        send_cmd(insert_of(16'h0001, 8'h02, 8'd3, 8'd1, 16'h8086, 16'h1234,
                           8'h02, 8'h00, 8'h10));
        send_cmd(insert_of(16'h0001, 8'h02, 8'd3, 8'd1, 16'h8086, 16'h1234,
                           8'h02, 8'h00, 8'h10));
        // same location, lower interface byte: lands ahead of the pair
        send_cmd(insert_of(16'h0001, 8'h02, 8'd3, 8'd1, 16'h8086, 16'h1234,
                           8'h02, 8'h00, 8'h0F));
        for (int i = 0; i <= 5; i++) send_cmd(read_at(i));
        send_cmd(read_at(DEPTH - 1));
        send_cmd(bare(OP_NONE));
        send_cmd(bare(OP_CLEAR));
        send_cmd(read_at(0));
        send_cmd(insert_of(16'h0000, 8'h00, 8'd0, 8'd0, 16'hABCD, 16'h0000,
                           8'h00, 8'h00, 8'h00));
        send_cmd(read_at(0));
        drain();

        fill_table();
        drain();

        // random part
        for (int n = 0; n < MIXED_ITEMS; n++)
        begin
            if (n % 100 == 0)
                idling = (n < MIXED_ITEMS - 150) && ($urandom_range(0, 2) != 0);
            if (n == MIXED_ITEMS / 2)
                fill_table();
            r = $urandom_range(0, 99);
            if (r < 50)
                send_cmd(rand_record(10));
            else if (r < 85)
                send_cmd(read_at(($urandom_range(0, 3) != 0) ? $urandom_range(0, 15)
                                                              : $urandom_range(0, DEPTH - 1)));
            else if (r < 89)
                send_cmd(bare(OP_CLEAR));
            else if (r < 93)
                send_cmd(bare(OP_NONE));
            else
                send_cmd(rand_record(0));
            if ($urandom_range(0, 199) == 0)
                drain();
        end

        drain();
        repeat (80) @(posedge clk);
        $display("%0d commands sent: %0d records placed, %0d full-table and %0d format rejects",
                 sent, placed_count, full_count, format_count);
        $display("reads: %0d returned an entry, %0d past the count; %0d clears",
                 hit_count, miss_count, clear_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout at %0t, %0d results still outstanding", $time, pending);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sorted_pci_function_table_unit.f */
src/spft_pkg.sv
src/spft_ram.sv
src/spft_datapath.sv
src/spft_ctrl.sv
src/sorted_pci_function_table_unit.sv
bench/spft_checker.sv
bench/tb_top.sv
